@@ src/tcs_pkg.sv @@
// Shared types and constants for the text console scroller.
package tcs_pkg;

    // Field widths of the stream words
    localparam int REQ_W       = 2;
    localparam int CHAR_W      = 8;
    localparam int ADDR_W      = 12;
    localparam int DATA_W      = 8;
    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Request kinds carried in tuser
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic op_now;        // finish a put, read or unknown item at accept
        logic scroll_start;  // latch the item and set up a bottom row sweep
        logic clear_start;   // set up a full store sweep
        logic sweep_scroll;  // write one cell of the bottom row
        logic sweep_clear;   // write one cell of the store
        logic scroll_end;    // move the row base and settle the cursor
        logic clear_end;     // home the cursor and the row base
        logic out_load;      // load the result word
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_scroll;   // input word is a put that scrolls
        logic is_clear;      // input word is a clear
        logic out_free;      // result register free at the next edge
        logic scroll_last;   // last cell of the bottom row sweep
        logic clear_last;    // last cell of the store sweep
    } t_sts;

endpackage

@@ src/tcs_ctrl.sv @@
// Controller state machine of the text console scroller.
module tcs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tcs_pkg::t_sts i_sts,
    output tcs_pkg::t_cmd o_cmd
);
    import tcs_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCROLL = 3'd1;
    localparam logic [2:0] ST_CLEAR  = 3'd2;
    localparam logic [2:0] ST_DONE   = 3'd3;

    logic [2:0] r_state, n_state;
    logic       r_init, n_init;
    logic       in_fire;

    assign o_in_ready = (r_state == ST_IDLE) && i_sts.out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    // Sequence each word through its work
    always_comb begin
        n_state = r_state;
        n_init  = r_init;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_sts.need_scroll) begin
                        o_cmd.scroll_start = 1'b1;
                        n_state = ST_SCROLL;
                    end else if (i_sts.is_clear) begin
                        o_cmd.clear_start = 1'b1;
                        n_state = ST_CLEAR;
                    end else begin
                        o_cmd.op_now = 1'b1;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCROLL: begin
                o_cmd.sweep_scroll = 1'b1;
                if (i_sts.scroll_last) begin
                    o_cmd.scroll_end = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_CLEAR: begin
                o_cmd.sweep_clear = 1'b1;
                if (i_sts.clear_last) begin
                    o_cmd.clear_end = 1'b1;
                    n_init  = 1'b0;
                    n_state = r_init ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.out_load = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Start in the power-up clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_init  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
        end
    end

endmodule

@@ src/tcs_datapath.sv @@
// Datapath of the text console scroller: character store, cursor and result register.
module tcs_datapath #(
    parameter int ROWS = 30,
    parameter int COLS = 80
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcs_pkg::t_cmd                 i_cmd,
    output tcs_pkg::t_sts                 o_sts,
    input  logic [tcs_pkg::REQ_W-1:0]     i_req_type,
    input  logic [tcs_pkg::CHAR_W-1:0]    i_char_in,
    input  logic [tcs_pkg::ADDR_W-1:0]    i_read_addr,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [tcs_pkg::DATA_W-1:0]    o_read_data,
    output logic [tcs_pkg::ROW_W-1:0]     o_row_out,
    output logic [tcs_pkg::COL_W-1:0]     o_col_out
);
    import tcs_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);

    localparam logic [AW:0]   CELLS_X = (AW+1)'(CELLS);
    localparam logic [AW-1:0] COLS_A  = AW'(COLS);

    logic [CHAR_W-1:0] mem [CELLS];

    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [AW-1:0]     r_rbase;   // cursor row times COLS
    logic [AW-1:0]     r_off;     // physical start of the top row
    logic [AW-1:0]     r_sw;
    logic [CW-1:0]     r_k;
    logic [CHAR_W-1:0] r_ch;
    logic              r_sc_ch;
    logic              r_rd_ok;
    logic [CHAR_W-1:0] r_mem_q;
    logic              r_out_v;
    logic [DATA_W-1:0] r_out_data;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;

    logic              is_put, is_lf, is_cr, last_row, end_col, put_wr;
    logic [AW-1:0]     wr_rbase;
    logic [CW-1:0]     wr_col;
    logic [AW:0]       wsum, rsum, osum;
    logic [AW-1:0]     put_addr, rd_idx, off_next;
    logic              rd_in_range;
    logic              we;
    logic [AW-1:0]     wa;
    logic [CHAR_W-1:0] wd;

    // Decode the input word
    assign is_put   = (i_req_type == REQ_PUT);
    assign is_lf    = (i_char_in == CH_LF);
    assign is_cr    = (i_char_in == CH_CR);
    assign last_row = (r_row == RW'(ROWS - 1));
    assign end_col  = (r_col == CW'(COLS - 1));
    assign put_wr   = is_put && !is_lf && !is_cr;

    assign o_sts.need_scroll = is_put && last_row && (is_lf || (!is_cr && end_col));
    assign o_sts.is_clear    = (i_req_type == REQ_CLEAR);
    assign o_sts.out_free    = !r_out_v || i_out_ready;
    assign o_sts.scroll_last = (r_k == CW'(COLS - 1));
    assign o_sts.clear_last  = (r_sw == AW'(CELLS - 1));

    // Map the cursor cell to its physical address, wrapping the row ring
    assign wr_rbase = end_col ? r_rbase + COLS_A : r_rbase;
    assign wr_col   = end_col ? '0 : r_col;
    assign wsum     = (AW+1)'(wr_rbase) + (AW+1)'(wr_col) + (AW+1)'(r_off);
    assign put_addr = (wsum >= CELLS_X) ? AW'(wsum - CELLS_X) : AW'(wsum);

    // Map the read index the same way
    assign rd_in_range = (32'(i_read_addr) < CELLS);
    assign rsum        = (AW+1)'(AW'(i_read_addr)) + (AW+1)'(r_off);
    assign rd_idx      = !rd_in_range ? '0 :
                         (rsum >= CELLS_X) ? AW'(rsum - CELLS_X) : AW'(rsum);

    // Advance the top row by one row on scroll
    assign osum     = (AW+1)'(r_off) + (AW+1)'(COLS);
    assign off_next = (osum >= CELLS_X) ? AW'(osum - CELLS_X) : AW'(osum);

    // Select the single write of this cycle
    always_comb begin
        we = 1'b0;
        wa = put_addr;
        wd = i_char_in;
        if (i_cmd.sweep_clear) begin
            we = 1'b1;
            wa = r_sw;
            wd = CH_SPACE;
        end else if (i_cmd.sweep_scroll) begin
            we = 1'b1;
            wa = r_sw;
            wd = (r_k == '0 && r_sc_ch) ? r_ch : CH_SPACE;
        end else if (i_cmd.op_now && put_wr) begin
            we = 1'b1;
        end
    end

    // Character store with a registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (i_cmd.op_now) begin
            r_mem_q <= mem[rd_idx];
        end
    end

    // Hold the item latched for a scroll
    always_ff @(posedge i_clk) begin
        if (i_cmd.scroll_start) begin
            r_ch    <= i_char_in;
            r_sc_ch <= !is_lf;
        end
    end

    // Cursor, row ring and sweep counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_rbase <= '0;
            r_off   <= '0;
            r_sw    <= '0;
            r_k     <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_cmd.op_now) begin
                r_rd_ok <= (i_req_type == REQ_READ) && rd_in_range;
                if (is_put) begin
                    if (is_lf) begin
                        r_row   <= r_row + 1'b1;
                        r_rbase <= r_rbase + COLS_A;
                        r_col   <= '0;
                    end else if (is_cr) begin
                        r_col   <= '0;
                    end else if (end_col) begin
                        r_row   <= r_row + 1'b1;
                        r_rbase <= r_rbase + COLS_A;
                        r_col   <= CW'(1);
                    end else begin
                        r_col   <= r_col + 1'b1;
                    end
                end
            end
            if (i_cmd.scroll_start) begin
                r_rd_ok <= 1'b0;
                r_sw    <= r_off;
                r_k     <= '0;
            end
            if (i_cmd.clear_start) begin
                r_rd_ok <= 1'b0;
                r_sw    <= '0;
            end
            if (i_cmd.sweep_scroll || i_cmd.sweep_clear) begin
                r_sw <= r_sw + 1'b1;
                r_k  <= r_k + 1'b1;
            end
            if (i_cmd.scroll_end) begin
                r_off <= off_next;
                r_col <= r_sc_ch ? CW'(1) : '0;
            end
            if (i_cmd.clear_end) begin
                r_row   <= '0;
                r_col   <= '0;
                r_rbase <= '0;
                r_off   <= '0;
            end
        end
    end

    // Result register: load on command, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_rd_ok ? DATA_W'(r_mem_q) : '0;
            r_out_row  <= ROW_W'(r_row);
            r_out_col  <= COL_W'(r_col);
        end
    end

    assign o_out_valid = r_out_v;
    assign o_read_data = r_out_data;
    assign o_row_out   = r_out_row;
    assign o_col_out   = r_out_col;

endmodule

@@ src/text_console_scroller.sv @@
// Top level of the text console scroller.
//
// Usage: one request word enters on the slave stream; tuser carries the kind
// (put character, clear screen, read cell) and tdata the character and the
// read index. Each word gives exactly one result word on the master stream
// with the read byte (zero unless a read) and the cursor after the word.
// From accept to result valid, the result register loads after:
//   put without scroll, carriage return, read, unknown kind: the store read
//   put that scrolls (line feed, or a character wrapping, on the last row):
//     the sweep that blanks the new bottom row;
//     rows are kept as a ring, so scrolling moves no stored data
//   clear: the sweep of the store, one store cell written per cycle
// One word is in work at a time; the next is taken after its result loads.
// Reset: synchronous, active low. After reset the block runs a clearing pass
// over all ROWS*COLS cells that fills the store with spaces; tready stays low
// during it. When the receiver stalls, the result word holds in the output
// register; the next word is taken in the cycle the held result is taken.
module text_console_scroller #(
    parameter int ROWS = 30,
    parameter int COLS = 80
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // char_in [7:0], read_addr [19:8], zero [23:20]
    input  logic [tcs_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // req_type [1:0]
    input  logic [tcs_pkg::REQ_W-1:0]           i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // read_data [7:0], row_out [12:8], col_out [19:13], zero [23:20]
    output logic [tcs_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);
    import tcs_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    logic [DATA_W-1:0] read_data;
    logic [ROW_W-1:0]  row_out;
    logic [COL_W-1:0]  col_out;

    tcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tcs_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_type  (i_s_axis_tuser),
        .i_char_in   (i_s_axis_tdata[CHAR_W-1:0]),
        .i_read_addr (i_s_axis_tdata[CHAR_W+ADDR_W-1:CHAR_W]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_read_data (read_data),
        .o_row_out   (row_out),
        .o_col_out   (col_out)
    );

    // Pack the result word
    assign o_m_axis_tdata = {{(OUT_TDATA_W-DATA_W-ROW_W-COL_W){1'b0}},
                             col_out, row_out, read_data};

endmodule

@@ src/tcs_checker.sv @@
// Port-level checks for the text console scroller, bound to the top level.
module tcs_checker #(
    parameter int ROWS = 30,
    parameter int COLS = 80
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_axis_tvalid,
    input logic                                o_s_axis_tready,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [tcs_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);
    import tcs_pkg::*;

    logic in_fire, out_fire;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;

    // Result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped before taken");

    // One word in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_s_axis_tready)
        else $error("word accepted while another is in work");

    // A taken result is not followed at once by another
    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire |=> !o_m_axis_tvalid)
        else $error("result without a word behind it");

    // Reported cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (32'(o_m_axis_tdata[DATA_W+ROW_W+COL_W-1:DATA_W+ROW_W]) < COLS) &&
            (32'(o_m_axis_tdata[DATA_W+ROW_W-1:DATA_W]) < ROWS))
        else $error("cursor off the screen");

endmodule

bind text_console_scroller tcs_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

@@ test/text_console_scroller_tb.sv @@
// Self-checking stream testbench for the text console scroller: directed table and random text.
module text_console_scroller_tb;
    import tcs_pkg::*;

    localparam int ROWS  = 30;
    localparam int COLS  = 80;
    localparam int CELLS = ROWS * COLS;

    // Kind code that the block ignores
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 1000;
    localparam int IDLE_PCT     = 33;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2500;
    localparam int MAX_PRINTS   = 50;

    // Result word fields
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_console_result;

    // One directed step: a word sent reps times, optionally with a typed result
    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        reps;
        logic              typed;
        t_console_result   result;
    } t_directed_step;

    localparam t_directed_step DIRECTED [24] = '{
        '{REQ_READ,   8'h00, 12'd0,    8'd1,  1'b1, '{8'h20, 5'd0, 7'd0}},
        '{REQ_READ,   8'hFF, 12'd2399, 8'd1,  1'b1, '{8'h20, 5'd0, 7'd0}},
        '{REQ_READ,   8'h00, 12'd2400, 8'd1,  1'b1, '{8'h00, 5'd0, 7'd0}},
        '{REQ_READ,   8'hA5, 12'hFFF,  8'd1,  1'b1, '{8'h00, 5'd0, 7'd0}},
        '{REQ_UNUSED, 8'hFF, 12'hFFF,  8'd1,  1'b1, '{8'h00, 5'd0, 7'd0}},
        '{REQ_PUT,    8'hFF, 12'h000,  8'd1,  1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_PUT,    8'h00, 12'hFFF,  8'd1,  1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_PUT,    CH_CR, 12'h000,  8'd1,  1'b1, '{8'h00, 5'd0, 7'd0}},
        '{REQ_PUT,    8'h41, 12'h000,  8'd1,  1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_READ,   8'h00, 12'd0,    8'd1,  1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_READ,   8'h00, 12'd1,    8'd1,  1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_PUT,    8'h78, 12'h000,  8'd78, 1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_PUT,    8'h79, 12'h000,  8'd1,  1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_READ,   8'h00, 12'd79,   8'd1,  1'b1, '{8'h20, 5'd1, 7'd1}},
        '{REQ_PUT,    CH_LF, 12'h000,  8'd28, 1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_PUT,    8'h7A, 12'h000,  8'd79, 1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_PUT,    8'h77, 12'h000,  8'd1,  1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_PUT,    CH_LF, 12'h000,  8'd1,  1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_READ,   8'h00, 12'd2320, 8'd1,  1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_READ,   8'h00, 12'd2240, 8'd1,  1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_READ,   8'h00, 12'd0,    8'd1,  1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_PUT,    8'h80, 12'h000,  8'd1,  1'b0, '{8'h00, 5'd0, 7'd0}},
        '{REQ_CLEAR,  8'hFF, 12'hFFF,  8'd1,  1'b1, '{8'h00, 5'd0, 7'd0}},
        '{REQ_READ,   8'h00, 12'd2399, 8'd1,  1'b1, '{8'h20, 5'd0, 7'd0}}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // char_in [7:0], read_addr [19:8], zero [23:20]
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    // req_type [1:0]
    logic [REQ_W-1:0]       i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // read_data [7:0], row_out [12:8], col_out [19:13], zero [23:20]
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    // Shadow copy of the console
    logic [CHAR_W-1:0]      shadow_screen [CELLS];
    logic [ROW_W-1:0]       shadow_row;
    logic [COL_W-1:0]       shadow_col;

    t_console_result        pending_results [$];
    int                     mismatch_count = 0;
    int                     words_sent = 0;
    bit                     no_gaps = 1'b0;
    bit                     hold_req = 1'b0;

    text_console_scroller #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Fill the shadow store with spaces
    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = CH_SPACE;
    endfunction

    // Move to the next row; on the last row shift every row up and blank the bottom
    function automatic void advance_row();
        shadow_col = '0;
        if (shadow_row >= ROWS - 1) begin
            for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = CH_SPACE;
        end else begin
            shadow_row = shadow_row + 1'b1;
        end
    endfunction

    // Apply one word to the shadow console and return the result it gives
    function automatic t_console_result console_predict(logic [REQ_W-1:0] kind,
                                                        logic [CHAR_W-1:0] ch,
                                                        logic [ADDR_W-1:0] addr);
        t_console_result res;
        res = '0;
        case (kind)
            REQ_PUT: begin
                if (ch == CH_LF) begin
                    advance_row();
                end else if (ch == CH_CR) begin
                    shadow_col = '0;
                end else begin
                    if (shadow_col >= COLS - 1) advance_row();
                    shadow_screen[shadow_row * COLS + shadow_col] = ch;
                    shadow_col = shadow_col + 1'b1;
                end
            end
            REQ_CLEAR: begin
                blank_screen();
                shadow_row = '0;
                shadow_col = '0;
            end
            REQ_READ: begin
                if (addr < CELLS) res.data = shadow_screen[addr];
            end
            default: ;
        endcase
        res.row = shadow_row;
        res.col = shadow_col;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offer one word, after a random gap unless no_gaps is set, and log its result once it is taken
    task automatic send_word(logic [REQ_W-1:0] kind, logic [CHAR_W-1:0] ch,
                             logic [ADDR_W-1:0] addr, bit typed = 1'b0,
                             t_console_result typed_result = '0);
        t_console_result res;
        if (!no_gaps) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, addr, ch};
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        res = console_predict(kind, ch, addr);
        pending_results.push_back(typed ? typed_result : res);
        if (kind != REQ_UNUSED) words_sent++;
    endtask

    // Drop valid and hold until every logged result has come back
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Pick a read index: mostly near the cursor or the bottom, sometimes anywhere
    function automatic logic [ADDR_W-1:0] read_target();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return ADDR_W'(shadow_row * COLS + $urandom_range(0, COLS - 1));
        if (pick < 70) return ADDR_W'($urandom_range(CELLS - 2 * COLS, CELLS - 1));
        if (pick < 90) return ADDR_W'($urandom_range(0, CELLS - 1));
        return ADDR_W'($urandom_range(0, 4095));
    endfunction

    // Receiver: random stalls, a quiet stretch, and one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Check each result word against the oldest logged result
    initial begin
        t_console_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word %h", o_m_axis_tdata));
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_axis_tdata[7:0] != want.data)
                        report_mismatch($sformatf("read_data %h, want %h",
                                                  o_m_axis_tdata[7:0], want.data));
                    if (o_m_axis_tdata[12:8] != want.row)
                        report_mismatch($sformatf("row_out %0d, want %0d",
                                                  o_m_axis_tdata[12:8], want.row));
                    if (o_m_axis_tdata[19:13] != want.col)
                        report_mismatch($sformatf("col_out %0d, want %0d",
                                                  o_m_axis_tdata[19:13], want.col));
                    if (o_m_axis_tdata[23:20] != 4'b0)
                        report_mismatch($sformatf("pad bits %h not zero",
                                                  o_m_axis_tdata[23:20]));
                end
            end
        end
    end

    // Watchdog
    initial begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus
    initial begin
        int  pick;
        int  len;
        bit  hold_done;
        bit  drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        blank_screen();
        shadow_row = '0;
        shadow_col = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: extremes, every kind, wrap and scroll cases
        for (int k = 0; k < 24; k++) begin
            for (int r = 0; r < DIRECTED[k].reps; r++) begin
                send_word(DIRECTED[k].kind, DIRECTED[k].ch, DIRECTED[k].addr,
                          DIRECTED[k].typed && (r == DIRECTED[k].reps - 1),
                          DIRECTED[k].result);
            end
        end
        words_sent = 0;

        // Random text: lines ending in line feeds, reads, noise, rare clears
        while (words_sent < RANDOM_WORDS) begin
            no_gaps = (words_sent >= 300 && words_sent < 500);
            if (!hold_done && words_sent >= 600) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (!drain_done && words_sent >= 900) begin
                drain_done = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(70, 90)
                                                  : $urandom_range(0, 12);
                repeat (len) send_word(REQ_PUT, CHAR_W'($urandom_range(0, 255)),
                                       ADDR_W'($urandom_range(0, 4095)));
                if ($urandom_range(0, 3) == 0)
                    send_word(REQ_PUT, CH_CR, ADDR_W'($urandom_range(0, 4095)));
                send_word(REQ_PUT, CH_LF, ADDR_W'($urandom_range(0, 4095)));
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4))
                    send_word(REQ_READ, CHAR_W'($urandom_range(0, 255)), read_target());
            end else if (pick < 92) begin
                // Return to column zero and overwrite a few cells
                send_word(REQ_PUT, CH_CR, ADDR_W'($urandom_range(0, 4095)));
                repeat ($urandom_range(1, 6))
                    send_word(REQ_PUT, CHAR_W'($urandom_range(0, 255)), read_target());
            end else if (pick < 99) begin
                case ($urandom_range(0, 2))
                    0: send_word(REQ_PUT, CHAR_W'($urandom_range(0, 255)),
                                 ADDR_W'($urandom_range(0, 4095)));
                    1: send_word(REQ_READ, CHAR_W'($urandom_range(0, 255)),
                                 ADDR_W'($urandom_range(0, 4095)));
                    default: send_word(REQ_UNUSED, CHAR_W'($urandom_range(0, 255)),
                                       ADDR_W'($urandom_range(0, 4095)));
                endcase
            end else begin
                send_word(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)),
                          ADDR_W'($urandom_range(0, 4095)));
            end
        end
        no_gaps = 1'b0;

        // Let every result come back, then watch for stray words
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
